// File: hdl/fcpf_pkg.sv
// Shared constants, types and codes for the firmware chunk packet framer.
package fcpf_pkg;

    // Chunk geometry
    localparam int CHUNK_BYTES = 8;
    localparam int CNT_W       = $clog2(CHUNK_BYTES + 1);
    localparam int IDX_W       = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_REG = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WRITE_CMD  = 2'd1;
    localparam logic [7:0] TARGET_REG_RST = 8'h08;
    localparam logic [7:0] WRITE_CMD_RST  = 8'h41;

    // Controller states
    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_TREG,
        ST_WCMD,
        ST_LEN,
        ST_DATA,
        ST_CHECK
    } state_t;

    // Source of the next packet byte
    typedef enum logic [2:0] {
        SRC_TREG,
        SRC_WCMD,
        SRC_LEN,
        SRC_DATA,
        SRC_CHECK
    } src_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // store the incoming image byte
        logic emit;     // load the output register
        src_t sel;      // which byte to load
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;   // output register can take a byte this cycle
        logic chunk_full;  // incoming byte fills the chunk
        logic last_data;   // current read index is the last held byte
    } dp_sts_t;

endpackage

// File: hdl/firmware_chunk_packet_framer_top.sv
// Top level of the firmware chunk packet framer: controller, datapath, checks.
//
// Image bytes arrive on the s_ stream, one request per byte; s_tlast marks the
// final image byte. Bytes are collected into chunks of up to CHUNK_BYTES (8).
// A full chunk, or the final byte, starts one packet on the m_ stream:
//   target register, write command, length, data bytes, checksum.
// The checksum is ~(command + length + sum of data), low byte; m_tlast is set
// on it only. Two registers are written through cfg_we/cfg_addr/cfg_wdata:
// index 0 the target register (reset 8), index 1 the write command (reset 65).
// Timing: an image byte is taken in each cycle with s_tvalid high while the
// chunk is being filled. Once the chunk closes, the controller sends
// length + 4 bytes, one per cycle while the output register is free, through
// the single output register, then reopens s_tready. The first packet byte
// is loaded from state ST_TREG, which is entered when the closing byte is taken.
// Reset (aresetn low, synchronous) empties the chunk, drops any pending output
// byte and restores both registers. A stalled receiver holds m_tdata/m_tlast;
// packet sequencing waits, and s_tready stays low until the checksum is loaded.
module firmware_chunk_packet_framer_top
    import fcpf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [7:0]            cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] image_byte
    input  logic                  s_tlast,   // image_end
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] packet_byte
    output logic                  m_tlast    // packet_end
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    fcpf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fcpf_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

    // No packet byte is produced while image bytes are being taken
    a_no_emit_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cmd.emit)
        else $error("packet byte emitted while collecting");

    // The output register is only loaded when it is free
    a_emit_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.slot_free)
        else $error("output byte overwritten before it was taken");

    // The final image byte always closes the chunk
    a_last_closes_chunk: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("final image byte did not start a packet");

endmodule

// File: hdl/fcpf_ctrl.sv
// Controller state machine: collects a chunk, then sequences the packet bytes.
module fcpf_ctrl
    import fcpf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    input  logic    s_tlast,
    output logic    s_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT: begin
                if (s_tvalid && (s_tlast || sts.chunk_full)) begin
                    state_next = ST_TREG;
                end
            end
            ST_TREG: begin
                if (sts.slot_free) state_next = ST_WCMD;
            end
            ST_WCMD: begin
                if (sts.slot_free) state_next = ST_LEN;
            end
            ST_LEN: begin
                if (sts.slot_free) state_next = ST_DATA;
            end
            ST_DATA: begin
                if (sts.slot_free && sts.last_data) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (sts.slot_free) state_next = ST_COLLECT;
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.emit   = 1'b0;
        cmd.sel    = SRC_TREG;
        case (state_reg)
            ST_COLLECT: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_TREG: begin
                cmd.emit = sts.slot_free;
                cmd.sel  = SRC_TREG;
            end
            ST_WCMD: begin
                cmd.emit = sts.slot_free;
                cmd.sel  = SRC_WCMD;
            end
            ST_LEN: begin
                cmd.emit = sts.slot_free;
                cmd.sel  = SRC_LEN;
            end
            ST_DATA: begin
                cmd.emit = sts.slot_free;
                cmd.sel  = SRC_DATA;
            end
            ST_CHECK: begin
                cmd.emit = sts.slot_free;
                cmd.sel  = SRC_CHECK;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/fcpf_datapath.sv
// Datapath: config registers, chunk store, count, running sum, output register.
module fcpf_datapath
    import fcpf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [7:0]            cfg_wdata,
    input  logic [7:0]            s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts
);

    localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(CHUNK_BYTES - 1);

    logic [7:0]       treg_reg;
    logic [7:0]       wcmd_reg;
    logic [7:0]       store_reg [CHUNK_BYTES];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] rd_idx_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [7:0]       m_tdata_reg;
    logic [7:0]       m_tdata_next;
    logic             m_tlast_reg;
    logic             m_tlast_next;
    logic [7:0]       len_byte;
    logic [7:0]       check_byte;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            treg_reg <= TARGET_REG_RST;
            wcmd_reg <= WRITE_CMD_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_TARGET_REG: treg_reg <= cfg_wdata;
                CFG_WRITE_CMD:  wcmd_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Chunk store, written at the fill position
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            store_reg[count_reg[IDX_W-1:0]] <= s_tdata;
        end
    end

    assign len_byte   = 8'(count_reg);
    assign check_byte = ~(wcmd_reg + len_byte + sum_reg);

    // Status toward the controller
    assign sts.slot_free  = !m_tvalid_reg || m_tready;
    assign sts.chunk_full = (count_reg == LAST_SLOT);
    assign sts.last_data  = ((rd_idx_reg + CNT_W'(1)) == count_reg);

    // Count, sum and read index
    always_comb begin
        count_next  = count_reg;
        sum_next    = sum_reg;
        rd_idx_next = rd_idx_reg;
        if (cmd.accept) begin
            count_next = count_reg + CNT_W'(1);
            sum_next   = sum_reg + s_tdata;
        end
        if (cmd.emit) begin
            case (cmd.sel)
                SRC_LEN:   rd_idx_next = '0;
                SRC_DATA:  rd_idx_next = rd_idx_reg + CNT_W'(1);
                SRC_CHECK: begin
                    count_next = '0;
                    sum_next   = '0;
                end
                default: ;
            endcase
        end
    end

    // Output register: holds a byte until the receiver takes it
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
            m_tlast_next  = 1'b0;
            case (cmd.sel)
                SRC_TREG:  m_tdata_next = treg_reg;
                SRC_WCMD:  m_tdata_next = wcmd_reg;
                SRC_LEN:   m_tdata_next = len_byte;
                SRC_DATA:  m_tdata_next = store_reg[rd_idx_reg[IDX_W-1:0]];
                SRC_CHECK: begin
                    m_tdata_next = check_byte;
                    m_tlast_next = 1'b1;
                end
                default:   m_tdata_next = check_byte;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            sum_reg      <= '0;
            rd_idx_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            rd_idx_reg   <= rd_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: bench/fcpf_checker.sv
// Scoreboard for the firmware chunk packet framer: predicts packet bytes and checks them.
module fcpf_checker
    import fcpf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [7:0]            cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] image_byte
    input  logic                  s_tlast,   // image_end
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,   // [7:0] packet_byte
    input  logic                  m_tlast,   // packet_end
    output int                    fail_count,
    output int                    pending,
    output int                    bytes_checked,
    output int                    packets_checked
);

    typedef struct packed {
        logic [7:0] pbyte;
        logic       closes;
    } pkt_byte_t;

    // Expected packet bytes, oldest first
    pkt_byte_t  pkt_bytes_q[$];

    // Shadow of the block: registers and the chunk being collected
    logic [7:0] shadow_target;
    logic [7:0] shadow_cmd;
    logic [7:0] chunk_mem [CHUNK_BYTES];
    int         held;
    logic [7:0] held_sum;

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("ERROR @%0t: %s", $realtime, what);
    endtask

    task automatic push_pkt_byte(input logic [7:0] b, input logic closes);
        pkt_byte_t e;
        e.pbyte  = b;
        e.closes = closes;
        pkt_bytes_q.push_back(e);
    endtask

    // Take one image byte; a full chunk or the end flag yields one packet
    task automatic frame_image_byte(input logic [7:0] img_byte, input logic img_end);
        logic [7:0] len8;
        logic [7:0] csum;
        if (held < CHUNK_BYTES) begin
            chunk_mem[held] = img_byte;
            held++;
            held_sum += img_byte;
        end
        if (held < CHUNK_BYTES && !img_end) begin
            return;
        end
        len8 = held[7:0];
        csum = ~(shadow_cmd + len8 + held_sum);
        push_pkt_byte(shadow_target, 1'b0);
        push_pkt_byte(shadow_cmd, 1'b0);
        push_pkt_byte(len8, 1'b0);
        for (int i = 0; i < held; i++) begin
            push_pkt_byte(chunk_mem[i], 1'b0);
        end
        push_pkt_byte(csum, 1'b1);
        held     = 0;
        held_sum = '0;
    endtask

    initial begin
        fail_count      = 0;
        pending         = 0;
        bytes_checked   = 0;
        packets_checked = 0;
    end

    // Register writes, result compare, then request prediction
    always @(posedge aclk) begin
        pkt_byte_t e;
        if (!aresetn) begin
            shadow_target = TARGET_REG_RST;
            shadow_cmd    = WRITE_CMD_RST;
            held          = 0;
            held_sum      = '0;
            pkt_bytes_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_TARGET_REG: shadow_target = cfg_wdata;
                    CFG_WRITE_CMD:  shadow_cmd    = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (pkt_bytes_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected packet byte %h last=%b",
                                              m_tdata, m_tlast));
                end else begin
                    e = pkt_bytes_q.pop_front();
                    if (m_tdata !== e.pbyte) begin
                        report_mismatch($sformatf("packet byte %h, predicted %h",
                                                  m_tdata, e.pbyte));
                    end
                    if (m_tlast !== e.closes) begin
                        report_mismatch($sformatf("packet end %b, predicted %b on byte %h",
                                                  m_tlast, e.closes, e.pbyte));
                    end
                    bytes_checked++;
                    if (e.closes) begin
                        packets_checked++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                frame_image_byte(s_tdata, s_tlast);
            end
        end
        pending = pkt_bytes_q.size();
    end

endmodule

// File: bench/tb_firmware_chunk_packet_framer_top.sv
// Testbench top for the firmware chunk packet framer: clock, reset, stimulus, verdict.
module tb_firmware_chunk_packet_framer_top
    import fcpf_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;     // cycles after the last packet byte
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int PHASES      = 8;
    localparam int PHASE_BYTES = 60;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [7:0]            cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] image_byte
    logic                  s_tlast;   // image_end
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;   // [7:0] packet_byte
    logic                  m_tlast;   // packet_end

    int fail_count;
    int pending;
    int bytes_checked;
    int packets_checked;

    int cycle_count;
    int image_bytes_sent;
    int settings_used;
    bit tx_gaps;
    bit rx_gaps;
    int hold_asks;

    firmware_chunk_packet_framer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    fcpf_checker chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .pending         (pending),
        .bytes_checked   (bytes_checked),
        .packets_checked (packets_checked)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d packet bytes outstanding",
                     cycle_count, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, no-stall stretches, long hold-off on request
    initial begin
        int hold_seen;
        hold_seen = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    m_tready <= 1'b0;
                    @(posedge aclk);
                end
            end
            m_tready <= rx_gaps ? ($urandom_range(99) >= 38) : 1'b1;
        end
    end

    // One image byte request, with random idle cycles ahead of it
    task automatic send_image_byte(input logic [7:0] img_byte, input logic img_end);
        while (tx_gaps && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= img_byte;
        s_tlast  <= img_end;
        do @(posedge aclk); while (!s_tready);
        image_bytes_sent++;
    endtask

    function automatic logic [7:0] pick_image_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_image(input int len, input logic with_end);
        for (int i = 0; i < len; i++) begin
            send_image_byte(pick_image_byte(), with_end && (i == len - 1));
        end
    endtask

    // Sender pauses until every predicted packet byte is out
    task automatic wait_packets_out();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic poke_config(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    // Stimulus
    initial begin
        int phase_sent;
        int len;
        aresetn          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_addr         <= '0;
        cfg_wdata        <= '0;
        s_tvalid         <= 1'b0;
        s_tdata          <= '0;
        s_tlast          <= 1'b0;
        tx_gaps          = 1'b1;
        rx_gaps          = 1'b1;
        hold_asks        = 0;
        image_bytes_sent = 0;
        settings_used    = 1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: single-byte images at the byte extremes, reset registers
        send_image_byte(8'h00, 1'b1);
        send_image_byte(8'hFF, 1'b1);
        // Full chunk closes on its own, sum wraps
        for (int i = 0; i < CHUNK_BYTES; i++) begin
            send_image_byte(8'hFF, 1'b0);
        end
        // End flag on the byte that fills the chunk: one packet only
        for (int i = 1; i < CHUNK_BYTES; i++) begin
            send_image_byte(8'(i), 1'b0);
        end
        send_image_byte(8'h80, 1'b1);
        wait_packets_out();
        // Writes to unused indexes are ignored
        poke_config(CFG_SPARE_A, 8'h00);
        poke_config(CFG_SPARE_B, 8'hFF);
        send_image_byte(8'h5A, 1'b0);
        send_image_byte(8'hA5, 1'b1);
        // Register change while a partial chunk is held
        send_image_byte(8'h11, 1'b0);
        send_image_byte(8'h22, 1'b0);
        wait_packets_out();
        poke_config(CFG_WRITE_CMD, 8'hC3);
        settings_used++;
        send_image_byte(8'h33, 1'b1);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_packets_out();
            case (ph)
                0: begin
                    poke_config(CFG_TARGET_REG, 8'h00);
                    poke_config(CFG_WRITE_CMD, 8'h00);
                end
                1: begin
                    poke_config(CFG_TARGET_REG, 8'hFF);
                    poke_config(CFG_WRITE_CMD, 8'hFF);
                end
                4: begin
                    poke_config(CFG_TARGET_REG, TARGET_REG_RST);
                    poke_config(CFG_WRITE_CMD, WRITE_CMD_RST);
                    poke_config(CFG_SPARE_A, 8'($urandom));
                    poke_config(CFG_SPARE_B, 8'($urandom));
                end
                default: begin
                    poke_config(CFG_TARGET_REG, 8'($urandom));
                    poke_config(CFG_WRITE_CMD, 8'($urandom));
                end
            endcase
            settings_used++;
            tx_gaps = (ph != 2);
            rx_gaps = (ph != 2);
            // Receiver holds off while images keep coming
            if (ph == 3 || ph == 6) begin
                hold_asks++;
            end
            phase_sent = 0;
            while (phase_sent < PHASE_BYTES) begin
                len = ($urandom_range(99) < 80) ? $urandom_range(1, 9)
                                                : $urandom_range(10, 24);
                send_image(len, $urandom_range(99) < 85);
                phase_sent += len;
            end
        end
        // Flush whatever chunk is still held
        send_image_byte(pick_image_byte(), 1'b1);

        // Drain and settle
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4 * SETTLE) @(posedge aclk);

        $display("Sent %0d image bytes under %0d register settings", image_bytes_sent,
                 settings_used);
        $display("Checked %0d packets, %0d packet bytes, with stalls and hold-offs",
                 packets_checked, bytes_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/fcpf_pkg.sv
hdl/fcpf_ctrl.sv
hdl/fcpf_datapath.sv
hdl/firmware_chunk_packet_framer_top.sv
bench/fcpf_checker.sv
bench/tb_firmware_chunk_packet_framer_top.sv
